@@ rtl/u8d_pkg.sv @@
// Package for the UTF-8 stream decoder: byte-class bounds, the replacement
// scalar and the result beat type. No dependencies.
`default_nettype none

package u8d_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned PosW = 32;
  localparam int unsigned UseW = 3;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  localparam logic [7:0] AsciiTop  = 8'h80;
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] LeadSurr  = 8'hED;
  localparam logic [7:0] ContLo    = 8'h80;
  localparam logic [7:0] ContHi    = 8'hBF;
  localparam logic [7:0] ContLoE0  = 8'hA0;
  localparam logic [7:0] ContHiED  = 8'h9F;
  localparam logic [7:0] ContLoF0  = 8'h90;
  localparam logic [7:0] ContHiF4  = 8'h8F;
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic            ok;
    logic [UseW-1:0] used;
    logic [PosW-1:0] start;
    logic            fin;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
// UTF-8 stream decoder, top level: input register, decode logic, two-beat
// result queue. Depends on u8d_pkg.
`default_nettype none

// Usage
//   Input channel: one stream byte per beat (data_byte_i, end_of_stream_i),
//   taken when in_valid_i is high and in_stall_o is low. end_of_stream_i marks
//   the last byte; after it the stream offset starts again from zero.
//   Output channel: one beat per code point or ill-formed subpart, taken when
//   out_valid_o is high and out_stall_i is low. Ill-formed input gives U+FFFD
//   with well_formed_o low; final_result_o flags the last beat of an end byte.
//   Path: a taken byte is registered in the input register, decoded from there
//   combinationally, and its first result beat is registered in the result queue.
//   Throughput: one byte per cycle while the result queue has room. A byte that
//   breaks an open sequence gives two beats when it is itself ASCII or a bad
//   lead, or when as the end byte it opens a sequence that is then cut off.
//   The two-entry result queue absorbs them and, with the receiver taking every
//   beat, the input holds only while the queue drains one beat a cycle.
//   Stall: a stalled output keeps its beat; decoding goes on while the queue
//   has room for a byte's beats, then in_stall_o rises and the byte waits.
//   Reset: asynchronous, active low; empties the input register and the
//   queue and returns the decoder to "no sequence open, offset zero".
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            end_of_stream_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [CpW-1:0]       code_point_o,
  output logic                 well_formed_o,
  output logic [UseW-1:0]      bytes_used_o,
  output logic [PosW-1:0]      start_offset_o,
  output logic                 final_result_o
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       eos_q;

  // Decoder state
  logic [1:0]      need_q, need_d;
  logic [7:0]      lo_q, lo_d, hi_q, hi_d;
  logic [CpW-1:0]  ps_q, ps_d;
  logic [UseW-1:0] taken_q, taken_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] seq_q, seq_d;

  // Result queue, head in entry 0
  res_t       q_q [2];
  res_t       q_d [2];
  logic [1:0] cnt_q, cnt_d;

  res_t       r [2];
  logic [1:0] nres;
  logic       pop, proc, accept;
  logic [1:0] base, free;

  // Decode of the byte in the input register against the open sequence.
  always_comb begin
    logic [7:0] b;
    logic       in_range;
    logic [1:0] n;
    logic [1:0] need_m;
    res_t       x;
    b        = byte_q;
    in_range = (b >= lo_q) && (b <= hi_q);
    n        = 2'd0;
    need_m   = need_q;
    r[0]     = '0;
    r[1]     = '0;
    need_d   = need_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ps_d     = ps_q;
    taken_d  = taken_q;
    seq_d    = seq_q;
    x        = '0;

    if (need_q != 2'd0 && in_range) begin
      ps_d    = {ps_q[CpW-7:0], b[5:0] & ContMask[5:0]};
      taken_d = taken_q + 3'd1;
      need_m  = need_q - 2'd1;
      need_d  = need_m;
      lo_d    = ContLo;
      hi_d    = ContHi;
      if (need_m == 2'd0) begin
        x = '{cp: ps_d, ok: 1'b1, used: taken_d, start: seq_q, fin: 1'b0};
        r[n[0]] = x;
        n       = n + 2'd1;
        ps_d    = '0;
        taken_d = '0;
      end
    end else begin
      if (need_q != 2'd0) begin
        // broken sequence: replace what was taken, re-read this byte as lead
        x = '{cp: ReplChar, ok: 1'b0, used: taken_q, start: seq_q, fin: 1'b0};
        r[n[0]] = x;
        n       = n + 2'd1;
      end
      need_d  = 2'd0;
      lo_d    = ContLo;
      hi_d    = ContHi;
      ps_d    = '0;
      taken_d = '0;
      seq_d   = pos_q;
      if (b < AsciiTop) begin
        x = '{cp: {13'd0, b}, ok: 1'b1, used: 3'd1, start: pos_q, fin: 1'b0};
        r[n[0]] = x;
        n       = n + 2'd1;
      end else if (b >= Lead2Lo && b <= Lead2Hi) begin
        need_d  = 2'd1;
        ps_d    = {13'd0, b & Lead2Mask};
        taken_d = 3'd1;
      end else if (b >= Lead3Lo && b <= Lead3Hi) begin
        need_d  = 2'd2;
        ps_d    = {13'd0, b & Lead3Mask};
        taken_d = 3'd1;
        if (b == Lead3Lo)  lo_d = ContLoE0;
        if (b == LeadSurr) hi_d = ContHiED;
      end else if (b >= Lead4Lo && b <= Lead4Hi) begin
        need_d  = 2'd3;
        ps_d    = {13'd0, b & Lead4Mask};
        taken_d = 3'd1;
        if (b == Lead4Lo) lo_d = ContLoF0;
        if (b == Lead4Hi) hi_d = ContHiF4;
      end else begin
        x = '{cp: ReplChar, ok: 1'b0, used: 3'd1, start: pos_q, fin: 1'b0};
        r[n[0]] = x;
        n       = n + 2'd1;
      end
    end

    if (eos_q) begin
      if (need_d != 2'd0) begin
        // truncated at end of stream
        x = '{cp: ReplChar, ok: 1'b0, used: taken_d, start: seq_d, fin: 1'b0};
        r[n[0]] = x;
        n       = n + 2'd1;
      end
      if (n != 2'd0) r[1'(n - 2'd1)].fin = 1'b1;
      need_d  = 2'd0;
      lo_d    = ContLo;
      hi_d    = ContHi;
      ps_d    = '0;
      taken_d = '0;
      seq_d   = '0;
      pos_d   = '0;
    end else begin
      pos_d = pos_q + 32'd1;
    end
    nres = n;
  end

  // Handshake and queue bookkeeping
  assign pop        = (cnt_q != 2'd0) && !out_stall_i;
  assign base       = cnt_q - {1'b0, pop};
  assign free       = 2'd2 - base;
  assign proc       = in_vld_q && (nres <= free);
  assign in_stall_o = in_vld_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (proc ? 1'b0 : in_vld_q);

  always_comb begin
    q_d[0] = pop ? q_q[1] : q_q[0];
    q_d[1] = q_q[1];
    cnt_d  = base;
    if (proc) begin
      for (int i = 0; i < 2; i++) begin
        if (nres != 2'd0 && base == 2'(i)) q_d[i] = r[0];
        if (nres == 2'd2 && (base + 2'd1) == 2'(i)) q_d[i] = r[1];
      end
      cnt_d = base + nres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
      need_q   <= 2'd0;
      lo_q     <= ContLo;
      hi_q     <= ContHi;
      ps_q     <= '0;
      taken_q  <= '0;
      pos_q    <= '0;
      seq_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      cnt_q    <= cnt_d;
      if (proc) begin
        need_q  <= need_d;
        lo_q    <= lo_d;
        hi_q    <= hi_d;
        ps_q    <= ps_d;
        taken_q <= taken_d;
        pos_q   <= pos_d;
        seq_q   <= seq_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
    q_q[0] <= q_d[0];
    q_q[1] <= q_d[1];
  end

  assign out_valid_o    = cnt_q != 2'd0;
  assign code_point_o   = q_q[0].cp;
  assign well_formed_o  = q_q[0].ok;
  assign bytes_used_o   = q_q[0].used;
  assign start_offset_o = q_q[0].start;
  assign final_result_o = q_q[0].fin;

endmodule

`default_nettype wire

@@ rtl/u8d_checker.sv @@
// Port-level checks for the UTF-8 stream decoder and the bind that attaches
// them. Depends on u8d_pkg and utf8_stream_decoder.
`default_nettype none

module u8d_checker
  import u8d_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [CpW-1:0]  code_point_o,
  input wire logic            well_formed_o,
  input wire logic [UseW-1:0] bytes_used_o,
  input wire logic [PosW-1:0] start_offset_o,
  input wire logic            final_result_o
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o)
      && $stable(well_formed_o) && $stable(bytes_used_o)
      && $stable(start_offset_o) && $stable(final_result_o))
    else $error("stalled result beat changed");

  a_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !well_formed_o |-> code_point_o == ReplChar)
    else $error("ill-formed beat without U+FFFD");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bytes_used_o >= 3'd1 && bytes_used_o <= 3'd4)
    else $error("bytes used out of range");

  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && well_formed_o && bytes_used_o == 3'd1 |-> code_point_o < 21'h80)
    else $error("single-byte scalar above ASCII");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .code_point_o   (code_point_o),
  .well_formed_o  (well_formed_o),
  .bytes_used_o   (bytes_used_o),
  .start_offset_o (start_offset_o),
  .final_result_o (final_result_o)
);

`default_nettype wire
